FILE: rtl/sedf_pkg.sv
// ----------------------------------------------------------------------------
// sedf_pkg: shared types and constants for the STX/ETX and length/XOR deframer
// Frame delimiters, phase and verdict codes, register indexes and the result
// beat that travels from the framer to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sedf_pkg;

    // Framing bytes and sizes
    localparam logic [7:0]  STX_BYTE       = 8'h02;
    localparam logic [7:0]  ETX_BYTE       = 8'h03;
    localparam logic [32:0] FRAME_OVERHEAD = 33'd9;
    localparam int unsigned MAX_FRAME_W    = 17;
    localparam logic [MAX_FRAME_W-1:0] MAX_FRAME_RESET = 17'h10000;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROTOCOL_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd1;

    // Protocol mode codes
    localparam logic MODE_ASCII  = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    // Default depth of the result queue
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Framer phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT     = 5'b00001,
        PH_LENGTH   = 5'b00010,
        PH_PAYLOAD  = 5'b00100,
        PH_CHECKSUM = 5'b01000,
        PH_ASCII    = 5'b10000
    } phase_t;

    // Verdict carried on the last byte of a frame
    typedef enum logic [1:0] {
        VERDICT_PROGRESS = 2'd0,
        VERDICT_GOOD     = 2'd1,
        VERDICT_CHECKSUM = 2'd2,
        VERDICT_TOO_LONG = 2'd3
    } verdict_t;

    // One result beat
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_first;
        logic       frame_last;
        verdict_t   verdict;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/sedf_framer.sv
// ----------------------------------------------------------------------------
// sedf_framer: front end of the deframer
// Holds the configuration registers, tracks the frame phase and classifies
// each accepted byte as dropped or as a frame byte with its flags and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sedf_framer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [sedf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sedf_pkg::MAX_FRAME_W-1:0]    cfg_data,
    input  wire logic                                in_beat,
    input  wire logic [7:0]                          rx_byte,
    output logic                                     res_valid,
    output sedf_pkg::result_t                        res
);
    import sedf_pkg::*;

    logic                   mode_reg;
    logic [MAX_FRAME_W-1:0] max_reg;

    phase_t                 phase_reg,    phase_next;
    logic [1:0]             preamble_reg, preamble_next;
    logic [MAX_FRAME_W-1:0] pos_reg,      pos_next;
    logic [31:0]            len_reg,      len_next;
    logic [7:0]             xor_reg,      xor_next;

    logic [MAX_FRAME_W-1:0] pos_inc;
    logic [31:0]            len_shift;
    logic [32:0]            len_total;
    logic                   len_too_long;
    logic [MAX_FRAME_W:0]   payload_end;
    logic                   clear_frame;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ASCII;
            max_reg  <= MAX_FRAME_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_PROTOCOL_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_MAX_FRAME_BYTES)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    // Datapath helpers
    assign pos_inc      = pos_reg + 1'b1;
    assign len_shift    = {len_reg[23:0], rx_byte};
    assign len_total    = {1'b0, len_shift} + FRAME_OVERHEAD;
    assign len_too_long = len_total > {16'd0, max_reg};
    // payload length is below the limit here, so 17 bits hold it
    assign payload_end  = {1'b0, len_reg[MAX_FRAME_W-1:0]} + 18'd8;

    // Phase tracking and byte classification
    always_comb
    begin
        phase_next    = phase_reg;
        preamble_next = preamble_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        xor_next      = xor_reg;
        res_valid     = 1'b0;
        res.frame_byte  = rx_byte;
        res.frame_first = 1'b0;
        res.frame_last  = 1'b0;
        res.verdict     = VERDICT_PROGRESS;
        clear_frame     = 1'b0;

        if (in_beat)
        begin
            if (mode_reg == MODE_ASCII)
            begin
                if (phase_reg != PH_ASCII)
                begin
                    if (rx_byte == STX_BYTE)
                    begin
                        phase_next      = PH_ASCII;
                        pos_next        = 17'd1;
                        res_valid       = 1'b1;
                        res.frame_first = 1'b1;
                        if (17'd1 >= max_reg)
                        begin
                            res.frame_last = 1'b1;
                            res.verdict    = VERDICT_TOO_LONG;
                        end
                    end
                end
                else
                begin
                    pos_next  = pos_inc;
                    res_valid = 1'b1;
                    if (rx_byte == ETX_BYTE)
                    begin
                        res.frame_last = 1'b1;
                        res.verdict    = VERDICT_GOOD;
                    end
                    else if (pos_inc >= max_reg)
                    begin
                        res.frame_last = 1'b1;
                        res.verdict    = VERDICT_TOO_LONG;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_LENGTH:
                    begin
                        res_valid       = 1'b1;
                        res.frame_first = (pos_reg == 17'd4);
                        len_next        = len_shift;
                        pos_next        = pos_inc;
                        if (pos_inc >= 17'd8)
                        begin
                            if (len_too_long)
                            begin
                                res.frame_last = 1'b1;
                                res.verdict    = VERDICT_TOO_LONG;
                            end
                            else
                            begin
                                xor_next   = 8'd0;
                                phase_next = (len_shift == 32'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        res_valid = 1'b1;
                        xor_next  = xor_reg ^ rx_byte;
                        pos_next  = pos_inc;
                        if ({1'b0, pos_inc} >= payload_end)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                    end
                    PH_CHECKSUM:
                    begin
                        res_valid      = 1'b1;
                        res.frame_last = 1'b1;
                        res.verdict    = (rx_byte == xor_reg) ? VERDICT_GOOD
                                                              : VERDICT_CHECKSUM;
                    end
                    default:
                    begin
                        // hunt for four STX bytes in a row
                        if (rx_byte != STX_BYTE)
                        begin
                            preamble_next = 2'd0;
                        end
                        else if (preamble_reg == 2'd3)
                        begin
                            phase_next    = PH_LENGTH;
                            preamble_next = 2'd0;
                            pos_next      = 17'd4;
                            len_next      = 32'd0;
                            xor_next      = 8'd0;
                        end
                        else
                        begin
                            preamble_next = preamble_reg + 1'b1;
                        end
                    end
                endcase
            end

            if (res.frame_last)
            begin
                clear_frame = 1'b1;
            end
        end

        // mode change drops any frame in progress
        if (cfg_write && (cfg_index == CFG_PROTOCOL_MODE))
        begin
            clear_frame = 1'b1;
        end

        if (clear_frame)
        begin
            phase_next    = PH_HUNT;
            preamble_next = 2'd0;
            pos_next      = '0;
            len_next      = '0;
            xor_next      = '0;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            preamble_reg <= 2'd0;
            pos_reg      <= '0;
            len_reg      <= '0;
            xor_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            preamble_reg <= preamble_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            xor_reg      <= xor_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sedf_queue.sv
// ----------------------------------------------------------------------------
// sedf_queue: result queue of the deframer
// Short first-in first-out store between the framer and the result port; it
// lets the producer keep running while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sedf_queue #(
    parameter int unsigned DEPTH = sedf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire sedf_pkg::result_t  wr_data,
    input  wire logic               rd_en,
    output sedf_pkg::result_t       rd_data,
    output logic                    full,
    output logic                    empty
);
    import sedf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t           mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stx_etx_and_length_xor_deframer_core.sv
// Byte-stream deframer. Bytes are pushed in one per cycle and frame bytes come
// out of a result queue; bytes outside a frame are dropped. Protocol mode 0
// finds ASCII frames from STX through ETX, mode 1 finds binary frames of four
// STX magic bytes, a 32-bit big-endian length, the payload and an XOR
// checksum (the magic bytes are not passed on). The last byte of a frame
// carries the verdict: good, checksum error or too long, and hunting resumes
// with the next byte after any frame end. The framer classifies a byte in the
// cycle it is accepted and its result is written straight into the result
// queue; a byte is accepted every cycle while the result queue (QUEUE_DEPTH
// entries) has room; full rises only when the consumer has let the queue fill.
// Write the configuration registers only while the block is idle; writing
// protocol_mode drops any partial frame.
// ----------------------------------------------------------------------------
// stx_etx_and_length_xor_deframer_core: top level of the deframer
// Joins the framer front end to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_and_length_xor_deframer_core #(
    parameter int unsigned QUEUE_DEPTH = sedf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                cfg_write,
    input  wire logic [sedf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sedf_pkg::MAX_FRAME_W-1:0]    cfg_data,
    // received bytes
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [7:0]                          rx_byte,
    // frame bytes
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [7:0]                               frame_byte,
    output logic                                     frame_first,
    output logic                                     frame_last,
    output logic [1:0]                               verdict
);
    import sedf_pkg::*;

    logic    in_beat;
    logic    res_valid;
    result_t res;
    result_t head;

    assign in_beat = push && !full;

    sedf_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    sedf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    // Result ports
    assign frame_byte  = head.frame_byte;
    assign frame_first = head.frame_first;
    assign frame_last  = head.frame_last;
    assign verdict     = head.verdict;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the STX/ETX and length/XOR deframer
// Pushes byte streams in ASCII and binary framing modes, predicts every frame
// beat with a bit-level framer model kept in the bench, and checks the result
// queue beat by beat under random push gaps, pop stalls and a long hold-off.
// ----------------------------------------------------------------------------

module tb_top;

    import sedf_pkg::*;

    // Register indexes outside the register map; writes to them are dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [MAX_FRAME_W-1:0]  cfg_data  = '0;
    logic                    push      = 1'b0;
    logic                    full;
    logic [7:0]              rx_byte   = 8'h00;
    logic                    empty;
    logic                    pop       = 1'b0;
    logic [7:0]              frame_byte;
    logic                    frame_first;
    logic                    frame_last;
    logic [1:0]              verdict;

    // Bytes waiting to be pushed, and frame beats still owed by the block
    logic [7:0]  rx_pending[$];
    result_t     beats_due[$];

    // Idling controls
    int          send_pct  = 0;
    int          recv_pct  = 0;
    int          hold_left = 0;
    logic        recv_hold;

    // Run statistics
    int          error_count    = 0;
    int          bytes_planned  = 0;
    int          bytes_accepted = 0;
    int          beats_checked  = 0;
    int          frames_good    = 0;
    int          frames_bad_sum = 0;
    int          frames_too_long = 0;

    // Framer model state
    logic                    fr_mode;
    logic [MAX_FRAME_W-1:0]  fr_limit;
    phase_t                  fr_phase;
    logic [2:0]              fr_stx_run;
    logic [16:0]             fr_pos;
    logic [31:0]             fr_len;
    logic [7:0]              fr_xor;

    stx_etx_and_length_xor_deframer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .frame_byte  (frame_byte),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .verdict     (verdict)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------------
    function automatic void fr_clear();
        fr_phase   = PH_HUNT;
        fr_stx_run = '0;
        fr_pos     = '0;
        fr_len     = '0;
        fr_xor     = '0;
    endfunction

    // Owe one beat; a frame end sends the model back to hunting
    function automatic void owe_beat(input logic [7:0] b, input logic first, input logic last,
                                     input verdict_t v);
        result_t r;
        r.frame_byte  = b;
        r.frame_first = first;
        r.frame_last  = last;
        r.verdict     = v;
        beats_due = {beats_due, r};
        if (last)
            fr_clear();
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic first;
        if (fr_mode == MODE_ASCII)
        begin
            if (fr_phase != PH_ASCII)
            begin
                if (b == STX_BYTE)
                begin
                    fr_phase = PH_ASCII;
                    fr_pos   = 17'd1;
                    if (fr_pos >= fr_limit)
                        owe_beat(b, 1'b1, 1'b1, VERDICT_TOO_LONG);
                    else
                        owe_beat(b, 1'b1, 1'b0, VERDICT_PROGRESS);
                end
            end
            else
            begin
                fr_pos = fr_pos + 17'd1;
                if (b == ETX_BYTE)
                    owe_beat(b, 1'b0, 1'b1, VERDICT_GOOD);
                else if (fr_pos >= fr_limit)
                    owe_beat(b, 1'b0, 1'b1, VERDICT_TOO_LONG);
                else
                    owe_beat(b, 1'b0, 1'b0, VERDICT_PROGRESS);
            end
            return;
        end

        case (fr_phase)
            PH_LENGTH:
            begin
                first  = (fr_pos == 17'd4);
                fr_len = {fr_len[23:0], b};
                fr_pos = fr_pos + 17'd1;
                if (fr_pos < 17'd8)
                    owe_beat(b, first, 1'b0, VERDICT_PROGRESS);
                else if ({1'b0, fr_len} + FRAME_OVERHEAD > {16'b0, fr_limit})
                    owe_beat(b, first, 1'b1, VERDICT_TOO_LONG);
                else
                begin
                    fr_xor   = '0;
                    fr_phase = (fr_len == 32'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                    owe_beat(b, first, 1'b0, VERDICT_PROGRESS);
                end
            end
            PH_PAYLOAD:
            begin
                fr_xor = fr_xor ^ b;
                fr_pos = fr_pos + 17'd1;
                if ({16'b0, fr_pos} >= {1'b0, fr_len} + 33'd8)
                    fr_phase = PH_CHECKSUM;
                owe_beat(b, 1'b0, 1'b0, VERDICT_PROGRESS);
            end
            PH_CHECKSUM:
                owe_beat(b, 1'b0, 1'b1, (b == fr_xor) ? VERDICT_GOOD : VERDICT_CHECKSUM);
            default:
            begin
                // magic word hunt: four STX in a row open the frame
                if (b != STX_BYTE)
                    fr_stx_run = '0;
                else
                begin
                    fr_stx_run = fr_stx_run + 3'd1;
                    if (fr_stx_run >= 3'd4)
                    begin
                        fr_phase   = PH_LENGTH;
                        fr_stx_run = '0;
                        fr_pos     = 17'd4;
                        fr_len     = '0;
                        fr_xor     = '0;
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_beat();
        result_t want;
        if (beats_due.size() == 0)
        begin
            report_mismatch("beat with none due", {24'b0, frame_byte}, 32'b0);
            return;
        end
        want = beats_due.pop_front();
        beats_checked++;
        if (frame_byte !== want.frame_byte)
            report_mismatch("frame_byte", {24'b0, frame_byte}, {24'b0, want.frame_byte});
        if (frame_first !== want.frame_first)
            report_mismatch("frame_first", {31'b0, frame_first}, {31'b0, want.frame_first});
        if (frame_last !== want.frame_last)
            report_mismatch("frame_last", {31'b0, frame_last}, {31'b0, want.frame_last});
        if (verdict !== want.verdict)
            report_mismatch("verdict", {30'b0, verdict}, {30'b0, want.verdict});
        case (want.verdict)
            VERDICT_GOOD:     frames_good++;
            VERDICT_CHECKSUM: frames_bad_sum++;
            VERDICT_TOO_LONG: frames_too_long++;
            default:          ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: feeds rx_pending into the push side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                deframe_byte(rx_byte);
                bytes_accepted++;
            end
            if (!push || !full)
            begin
                if (rx_pending.size() != 0 && $urandom_range(99) >= send_pct)
                begin
                    push    <= 1'b1;
                    rx_byte <= rx_pending.pop_front();
                end
                else
                begin
                    push    <= 1'b0;
                    rx_byte <= 8'($urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long pop hold-off, counted down in cycles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    assign recv_hold = (hold_left != 0);

    // ------------------------------------------------------------------------
    // Monitor: pops result beats and checks them
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_beat();
            pop <= !recv_hold && ($urandom_range(99) >= recv_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_rx(input logic [7:0] b);
        rx_pending = {rx_pending, b};
        bytes_planned++;
    endfunction

    // Line noise, with STX and ETX mixed in
    function automatic void add_noise(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(9);
            if (r == 0)
                queue_rx(STX_BYTE);
            else if (r == 1)
                queue_rx(ETX_BYTE);
            else
                queue_rx(8'($urandom));
        end
    endfunction

    // STX, body without ETX (STX allowed), optional closing ETX
    function automatic void add_ascii_frame(input int body, input bit closed);
        logic [7:0] b;
        queue_rx(STX_BYTE);
        for (int i = 0; i < body; i++)
        begin
            b = ($urandom_range(7) == 0) ? STX_BYTE : 8'($urandom);
            if (b == ETX_BYTE)
                b = 8'h83;
            queue_rx(b);
        end
        if (closed)
            queue_rx(ETX_BYTE);
    endfunction

    // Magic word, big-endian length, payload and checksum; long lengths stop
    // after the length field since the frame ends there
    function automatic void add_binary_frame(input logic [31:0] len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        repeat (4) queue_rx(STX_BYTE);
        for (int i = 3; i >= 0; i--)
            queue_rx(len[8*i +: 8]);
        if (len <= 32'd64)
        begin
            for (int i = 0; i < int'(len); i++)
            begin
                b   = 8'($urandom);
                sum = sum ^ b;
                queue_rx(b);
            end
            queue_rx(bad_sum ? sum ^ 8'(1 << $urandom_range(7)) : sum);
        end
    endfunction

    // Wait until every byte is in and every beat is out, then let the
    // framer settle
    task automatic drain();
        @(negedge clk);
        while (rx_pending.size() != 0 || push || beats_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the model follows at once since the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [MAX_FRAME_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_PROTOCOL_MODE)
        begin
            fr_mode = val[0];
            fr_clear();
        end
        else if (idx == CFG_MAX_FRAME_BYTES)
            fr_limit = val;
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                     stop;
        int                     r;
        int                     lim;
        int                     cap;
        logic                   mode;
        logic [MAX_FRAME_W-1:0] limit;

        fr_mode  = MODE_ASCII;
        fr_limit = MAX_FRAME_RESET;
        fr_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ASCII: a dropped byte, STX and 0x00 inside a body, then a frame left open
        queue_rx(8'hFF);
        queue_rx(STX_BYTE);
        queue_rx(8'h00);
        queue_rx(STX_BYTE);
        queue_rx(ETX_BYTE);
        queue_rx(STX_BYTE);
        queue_rx(8'h41);
        drain();

        // Limit drops under the open frame; its ninth byte ends it as too long
        write_reg(CFG_MAX_FRAME_BYTES, 17'd9);
        finish_writes();
        for (int i = 8'h42; i <= 8'h48; i++)
            queue_rx(8'(i));
        drain();

        // Limit below two: a lone STX is already too long
        write_reg(CFG_MAX_FRAME_BYTES, 17'd1);
        finish_writes();
        queue_rx(STX_BYTE);
        drain();

        // Binary: fifth STX is the first length byte, huge length is too long
        write_reg(CFG_PROTOCOL_MODE, 17'(MODE_BINARY));
        write_reg(CFG_MAX_FRAME_BYTES, MAX_FRAME_RESET);
        finish_writes();
        repeat (5) queue_rx(STX_BYTE);
        repeat (3) queue_rx(8'hFF);
        drain();

        // Random phases: ASCII then binary, each through all idling mixes
        for (int k = 0; k < 8; k++)
        begin
            mode = (k >= 4) ? MODE_BINARY : MODE_ASCII;
            case (k)
                0, 4:    limit = 17'd9;
                1, 5:    limit = MAX_FRAME_RESET;
                2:       limit = 17'($urandom_range(10, 30));
                6:       limit = 17'($urandom_range(12, 40));
                3:       limit = 17'd20;
                default: limit = 17'h1FFFF;
            endcase
            lim = int'(limit);
            cap = (lim - 9 < 24) ? lim - 9 : 24;

            case (k % 4)
                0:       begin send_pct <= 0;  recv_pct <= 0;  end
                1:       begin send_pct <= 46; recv_pct <= 0;  end
                2:       begin send_pct <= 0;  recv_pct <= 46; end
                default: begin send_pct <= 36; recv_pct <= 36; end
            endcase

            if (k == 3)
            begin
                write_reg(CFG_SPARE_LO, 17'($urandom));
                write_reg(CFG_SPARE_HI, 17'($urandom));
            end
            write_reg(CFG_PROTOCOL_MODE, 17'(mode));
            write_reg(CFG_MAX_FRAME_BYTES, limit);
            finish_writes();

            stop = bytes_planned + 145;
            while (bytes_planned < stop)
            begin
                r = $urandom_range(99);
                if (mode == MODE_ASCII)
                begin
                    if (r < 60)
                        add_ascii_frame($urandom_range(0, 12), 1'b1);
                    else if (r < 72)
                        add_ascii_frame((lim <= 40) ? $urandom_range(lim - 3, lim + 2)
                                                    : $urandom_range(13, 40), 1'b1);
                    else if (r < 82)
                        add_ascii_frame($urandom_range(0, 5), 1'b0);
                    else
                        add_noise($urandom_range(1, 6));
                end
                else
                begin
                    if (r < 55)
                        add_binary_frame(32'($urandom_range(0, cap)), 1'b0);
                    else if (r < 68)
                        add_binary_frame(32'($urandom_range(0, cap)), 1'b1);
                    else if (r < 78)
                        add_binary_frame(r[0] ? 32'(lim - 8 + $urandom_range(0, 3))
                                              : ($urandom | 32'h0004_0000),
                                         1'($urandom_range(1)));
                    else if (r < 88)
                    begin
                        // preamble cut short
                        repeat ($urandom_range(1, 3)) queue_rx(STX_BYTE);
                        queue_rx(8'($urandom_range(3, 255)));
                    end
                    else
                        add_noise($urandom_range(1, 6));
                end
            end

            // leave a frame open so the next mode write has to drop it
            if ($urandom_range(1) == 1)
            begin
                if (mode == MODE_ASCII)
                    add_ascii_frame($urandom_range(0, 3), 1'b0);
                else
                begin
                    repeat (4) queue_rx(STX_BYTE);
                    queue_rx(8'h00);
                end
            end

            // long pop hold-off while bytes keep coming, so full must rise
            if (k == 2)
                hold_left <= 300;
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Pushed %0d bytes in ASCII and binary modes, checked %0d frame beats",
                 bytes_accepted, beats_checked);
        $display("Frame ends seen: %0d good, %0d checksum error, %0d too long",
                 frames_good, frames_bad_sum, frames_too_long);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d beats still due", beats_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
